>>> design/dtoi_pkg.sv
`timescale 1ns / 1ps

package dtoi_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    status_t     err;
    logic        first;
    logic        digit;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    acc:   64'd0,
    neg:   1'b0,
    err:   ST_OK,
    first: 1'b1,
    digit: 1'b0
  };

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam int unsigned ADDR_W = 3;
  // Word index of the mode register (paddr bit 2).
  localparam logic REG_SIGNED_MODE = 1'b0;

endpackage

>>> design/decimal_text_to_int64_top.sv
`timescale 1ns / 1ps

// Decimal text to 64-bit integer parser.
// Input channel (in_valid/in_ready): one beat per character, char_code with
// no_char and is_last. A text ends with the beat that has is_last set; an empty
// text is a single beat with no_char and is_last both set.
// Output channel (out_valid/out_ready): one beat per text, carrying value_bits
// (two's complement when signed) and status (ok, empty, invalid, out of range).
// Configuration: APB-style port, register 0 bit 0 is signed_mode. Write it only
// while no text is in flight.
// Throughput is one beat per cycle while the output register can take results;
// a last beat waits in the input register while a result is still unclaimed.
// An accepted beat sits in the input register and is then folded into the
// accumulator; for a last beat the folded result then goes to the output register.
// The multiply-by-ten shift-add is the only wide arithmetic in the input path.
// When the receiver stalls, the result holds and the input register keeps the
// next last beat; beats that are not last still flow through.
// Reset clears signed_mode, the parse state and both valid flags; in_ready is
// low while rst is high.
module decimal_text_to_int64_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtoi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_code,
  input  logic                        no_char,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 value_bits,
  output logic [1:0]                  status
);

  logic signed_mode;

  logic       ivalid;
  logic [7:0] ichar;
  logic       inochar;
  logic       ilast;

  dtoi_pkg::parse_state_t parse;
  dtoi_pkg::parse_state_t parse_next;
  dtoi_pkg::parse_state_t stepped;

  dtoi_pkg::parse_state_t done;
  logic                   done_mode;

  logic out_free;
  logic advance;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == dtoi_pkg::REG_SIGNED_MODE) begin
      signed_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == dtoi_pkg::REG_SIGNED_MODE) begin
      prdata = {31'd0, signed_mode};
    end
  end

  // Handshake: a beat that is not last never needs the output register.
  assign out_free = !out_valid || out_ready;
  assign advance  = ivalid && (!ilast || out_free);
  assign in_ready = !rst && (!ivalid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (in_ready) begin
      ivalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ichar   <= char_code;
      inochar <= no_char;
      ilast   <= is_last;
    end
  end

  dtoi_step u_step (
    .cur         (parse),
    .char_code   (ichar),
    .no_char     (inochar),
    .signed_mode (signed_mode),
    .nxt         (stepped)
  );

  // The parse state starts over after every last beat.
  assign parse_next = ilast ? dtoi_pkg::PARSE_RESET : stepped;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse <= dtoi_pkg::PARSE_RESET;
    end else if (advance) begin
      parse <= parse_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ilast) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ilast) begin
      done      <= stepped;
      done_mode <= signed_mode;
    end
  end

  dtoi_finish u_finish (
    .fin         (done),
    .signed_mode (done_mode),
    .value_bits  (value_bits),
    .status      (status)
  );

endmodule

>>> design/dtoi_step.sv
`timescale 1ns / 1ps

module dtoi_step (
  input  dtoi_pkg::parse_state_t cur,
  input  logic [7:0]             char_code,
  input  logic                   no_char,
  input  logic                   signed_mode,
  output dtoi_pkg::parse_state_t nxt
);

  logic        is_digit;
  logic [3:0]  digit_val;
  logic [67:0] times_ten;
  logic        overflow;

  assign is_digit  = (char_code >= dtoi_pkg::CHAR_ZERO) && (char_code <= dtoi_pkg::CHAR_NINE);
  assign digit_val = char_code[3:0];

  // acc * 10 + d as (acc << 3) + (acc << 1) + d; any carry above bit 63 is overflow.
  assign times_ten = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {64'd0, digit_val};
  assign overflow  = |times_ten[67:64];

  always_comb begin
    nxt = cur;
    if (!no_char) begin
      nxt.first = 1'b0;
      if (cur.err == dtoi_pkg::ST_OK) begin
        if (is_digit) begin
          if (overflow) begin
            nxt.err = dtoi_pkg::ST_RANGE;
          end else begin
            nxt.acc   = times_ten[63:0];
            nxt.digit = 1'b1;
          end
        end else if (char_code == dtoi_pkg::CHAR_MINUS && cur.first && signed_mode) begin
          nxt.neg = 1'b1;
        end else begin
          nxt.err = dtoi_pkg::ST_INVALID;
        end
      end
    end
  end

endmodule

>>> design/dtoi_finish.sv
`timescale 1ns / 1ps

module dtoi_finish (
  input  dtoi_pkg::parse_state_t fin,
  input  logic                   signed_mode,
  output logic [63:0]            value_bits,
  output logic [1:0]             status
);

  dtoi_pkg::status_t st;
  logic [63:0]       val;

  always_comb begin
    st  = fin.err;
    val = 64'd0;
    if (st == dtoi_pkg::ST_OK && !fin.digit) begin
      st = fin.first ? dtoi_pkg::ST_EMPTY : dtoi_pkg::ST_INVALID;
    end
    if (st == dtoi_pkg::ST_OK) begin
      if (fin.neg) begin
        if (fin.acc > dtoi_pkg::NEG_LIMIT) begin
          st = dtoi_pkg::ST_RANGE;
        end else begin
          val = 64'd0 - fin.acc;
        end
      end else if (signed_mode) begin
        if (fin.acc[63]) begin
          st = dtoi_pkg::ST_RANGE;
        end else begin
          val = fin.acc;
        end
      end else begin
        val = fin.acc;
      end
    end
    if (st != dtoi_pkg::ST_OK) begin
      val = 64'd0;
    end
  end

  assign value_bits = val;
  assign status     = st;

endmodule

>>> design/dtoi_checker.sv
`timescale 1ns / 1ps

module dtoi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value_bits,
  input logic [1:0]  status
);

  // No result survives reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_bits) && $stable(status))
    else $error("stalled result changed");

  // Any failing status reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dtoi_pkg::ST_OK |-> value_bits == 64'd0)
    else $error("nonzero value with error status");

  // A fresh result must be preceded by an accepted last input beat.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && is_last, 2))
    else $error("result without a last input beat");

endmodule

bind decimal_text_to_int64_top dtoi_checker u_dtoi_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .is_last    (is_last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value_bits (value_bits),
  .status     (status)
);

>>> bench/tb_decimal_text_to_int64_top.sv
`timescale 1ns / 1ps

module tb_decimal_text_to_int64_top;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BEATS_PER_PHASE = 182;
  localparam int NUM_PHASES = 8;
  localparam logic [7:0] CHAR_PLUS = 8'h2b;
  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [dtoi_pkg::ADDR_W-1:0] MODE_ADDR = {dtoi_pkg::REG_SIGNED_MODE, 2'b00};
  localparam int unsigned SENDER_IDLE [4] = '{0, 72, 0, 9};
  localparam int unsigned RECEIVER_STALL [4] = '{0, 0, 72, 9};

  typedef struct packed {
    logic [7:0] code;
    logic       blank;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [63:0]        value;
    dtoi_pkg::status_t  st;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dtoi_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_code = '0;
  logic no_char = 1'b0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] value_bits;
  logic [1:0] status;

  decimal_text_to_int64_top DUT (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  text_beat_t beat_q[$];
  parse_result_t result_q[$];
  int unsigned beats_queued = 0;
  int unsigned beats_offered = 0;
  int unsigned beats_taken = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned texts_checked = 0;
  int unsigned status_count [4] = '{default: 0};

  // Shadow copy of the mode register and of the parse state of the current text.
  logic mode_signed = 1'b0;
  logic [63:0] text_acc;
  logic text_neg;
  dtoi_pkg::status_t text_err;
  logic text_fresh;
  logic text_has_digit;

  task automatic clear_text();
    text_acc = '0;
    text_neg = 1'b0;
    text_err = dtoi_pkg::ST_OK;
    text_fresh = 1'b1;
    text_has_digit = 1'b0;
  endtask

  task automatic fold_beat(input logic [7:0] code, input logic blank, input logic last);
    logic [67:0] scaled;
    logic was_fresh;
    parse_result_t res;
    if (!blank) begin
      was_fresh = text_fresh;
      text_fresh = 1'b0;
      // Once an error is latched the rest of the text is ignored.
      if (text_err == dtoi_pkg::ST_OK) begin
        if (code >= dtoi_pkg::CHAR_ZERO && code <= dtoi_pkg::CHAR_NINE) begin
          scaled = {4'b0, text_acc} * 68'd10 + 68'(code - dtoi_pkg::CHAR_ZERO);
          if (scaled[67:64] != 4'b0) begin
            text_err = dtoi_pkg::ST_RANGE;
          end else begin
            text_acc = scaled[63:0];
            text_has_digit = 1'b1;
          end
        end else if (code == dtoi_pkg::CHAR_MINUS && was_fresh && mode_signed) begin
          text_neg = 1'b1;
        end else begin
          text_err = dtoi_pkg::ST_INVALID;
        end
      end
    end
    if (last) begin
      res.st = text_err;
      res.value = '0;
      if (res.st == dtoi_pkg::ST_OK && !text_has_digit) begin
        res.st = text_fresh ? dtoi_pkg::ST_EMPTY : dtoi_pkg::ST_INVALID;
      end
      if (res.st == dtoi_pkg::ST_OK) begin
        if (text_neg) begin
          if (text_acc > dtoi_pkg::NEG_LIMIT) res.st = dtoi_pkg::ST_RANGE;
          else res.value = -text_acc;
        end else if (mode_signed && text_acc > MAX_POS) begin
          res.st = dtoi_pkg::ST_RANGE;
        end else begin
          res.value = text_acc;
        end
      end
      result_q.push_back(res);
      clear_text();
    end
  endtask

  // Input side: a new beat is presented only once the previous one was taken.
  always @(negedge clk) begin
    text_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (beats_taken == beats_offered) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = beat_q.pop_front();
        in_valid <= 1'b1;
        char_code <= nxt.code;
        no_char <= nxt.blank;
        is_last <= nxt.last;
        beats_offered <= beats_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        beats_taken <= beats_taken + 1;
        fold_beat(char_code, no_char, is_last);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with no text pending: value %h status %0d",
                   $time, value_bits, status);
          error_count++;
        end else begin
          want = result_q.pop_front();
          texts_checked++;
          status_count[want.st]++;
          if (value_bits !== want.value) begin
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, want.value, value_bits);
            error_count++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.st, status);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    while (beat_q.size() != 0 || beats_taken != beats_offered || result_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the mode register, then read it back.
  task automatic write_mode(input logic mode);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= {31'b0, mode};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== mode) begin
      $display("%0t: mode readback mismatch: expected %0d, actual %0d",
               $time, mode, prdata[0]);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    mode_signed = mode;
  endtask

  task automatic push_beat(input logic [7:0] code, input logic blank, input logic last);
    beat_q.push_back(text_beat_t'{code, blank, last});
    beats_queued++;
  endtask

  // An empty character list with end_blank clear still yields a closing empty beat.
  task automatic queue_text(input logic [7:0] txt[$], input int unsigned blank_pct,
                            input bit end_blank);
    foreach (txt[i]) begin
      if ($urandom_range(99) < blank_pct) push_beat(8'($urandom), 1'b1, 1'b0);
      push_beat(txt[i], 1'b0, !end_blank && i == txt.size() - 1);
    end
    if (end_blank || txt.size() == 0) begin
      if ($urandom_range(99) < blank_pct) push_beat(8'($urandom), 1'b1, 1'b0);
      push_beat(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  task automatic queue_str(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_text(txt, 0, 1'b0);
  endtask

  task automatic queue_random_text();
    logic [7:0] txt[$];
    logic [127:0] mag;
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    kind = $urandom_range(99);
    if (kind < 60 || (kind >= 75 && kind < 85)) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      repeat (len) txt.push_back(dtoi_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    end else if (kind < 75) begin
      // Magnitudes around the unsigned and signed limits, where the carry check bites.
      case ($urandom_range(4))
        0: mag = 128'h7fff_ffff_ffff_ffff;
        1: mag = 128'h8000_0000_0000_0000;
        2: mag = 128'hffff_ffff_ffff_ffff;
        3: mag = 128'h1_0000_0000_0000_0000;
        default: mag = 128'd1844674407370955161;
      endcase
      mag = mag + $urandom_range(6) - 3;
      do begin
        txt.push_front(dtoi_pkg::CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if ($urandom_range(7) == 0) txt.push_front(dtoi_pkg::CHAR_ZERO);
    end else if (kind >= 85) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(3))
          0: txt.push_back(dtoi_pkg::CHAR_ZERO + 8'($urandom_range(9)));
          1: txt.push_back($urandom_range(1) ? dtoi_pkg::CHAR_MINUS : CHAR_PLUS);
          default: txt.push_back(8'($urandom));
        endcase
      end
    end
    if (kind >= 10 && kind < 85) begin
      pick = $urandom_range(99);
      if (pick < (mode_signed ? 50 : 8)) txt.push_front(dtoi_pkg::CHAR_MINUS);
      else if (pick < (mode_signed ? 55 : 12)) txt.push_front(CHAR_PLUS);
    end
    // A broken text: one character replaced by an arbitrary byte.
    if (kind >= 75 && kind < 85) txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
    if (kind < 10) txt.delete();
    queue_text(txt, 8, $urandom_range(9) == 0);
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned start;
    start = beats_queued;
    while (beats_queued - start < count) queue_random_text();
  endtask

  initial begin
    clear_text();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      wait_idle();
      write_mode(1'(phase_idx % 2));
      sender_idle_pct = SENDER_IDLE[phase_idx / 2];
      receiver_stall_pct = RECEIVER_STALL[phase_idx / 2];
      if (phase_idx == 0) begin
        queue_str("0");
        queue_str("9");
        queue_str("-");
        queue_str("+1");
        queue_str("x7");
        push_beat(8'h5a, 1'b1, 1'b1);
        push_beat("1", 1'b0, 1'b0);
        push_beat(8'ha5, 1'b1, 1'b0);
        push_beat("2", 1'b0, 1'b1);
        push_beat(8'hff, 1'b0, 1'b1);
        push_beat(8'h00, 1'b0, 1'b1);
        push_beat("7", 1'b0, 1'b0);
        push_beat(8'h3c, 1'b1, 1'b1);
      end else if (phase_idx == 1) begin
        queue_str("-0");
        queue_str("-");
        queue_str("+3");
        queue_str("4-");
        queue_str("--1");
        queue_str("-9");
      end
      fill_random(BEATS_PER_PHASE / 2);
      // Let the block run dry before the second half.
      wait_idle();
      fill_random(BEATS_PER_PHASE / 2);
    end
    while (beat_q.size() != 0 || beats_taken != beats_offered) @(posedge clk);
    for (int n = 0; n < 2000 && result_q.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      error_count += result_q.size();
    end
    $display("Parsed %0d texts from %0d beats in unsigned and signed mode under four idle mixes.",
             texts_checked, beats_queued);
    $display("Results: %0d ok, %0d empty, %0d invalid, %0d out of range; %0d mismatches.",
             status_count[dtoi_pkg::ST_OK], status_count[dtoi_pkg::ST_EMPTY],
             status_count[dtoi_pkg::ST_INVALID], status_count[dtoi_pkg::ST_RANGE],
             error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
